// ===== rtl/delta_list_timer_queue_defines.svh =====
// ----------------------------------------------------------------------------
// delta_list_timer_queue_defines
// Assertion macros shared by the timer queue RTL.
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_TIMER_QUEUE_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define DLTQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define DLTQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dltq_pkg.sv =====
// ----------------------------------------------------------------------------
// dltq_pkg
// Types, codes and defaults for the delta list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int TIME_WIDTH_DEF = 32;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_EXPIRE = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic pop;   // take the right neighbor's entry
    logic load;  // take the pushed entry
    logic hwr;   // rewrite own delta in place
  } cell_ctrl_t;

endpackage

// ===== rtl/dltq_if.sv =====
// ----------------------------------------------------------------------------
// dltq_if
// Request and result channels of the delta list timer queue.
// ----------------------------------------------------------------------------
interface dltq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] tag;
  logic [31:0] timeout_ticks;
  logic [15:0] elapsed_ticks;

  modport source(output valid, action, tag, timeout_ticks, elapsed_ticks, input ready);
  modport sink(input valid, action, tag, timeout_ticks, elapsed_ticks, output ready);
endinterface

interface dltq_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] tag_res;
  logic [1:0]  status;
  logic        last;

  modport source(output valid, kind, tag_res, status, last, input ready);
  modport sink(input valid, kind, tag_res, status, last, output ready);
endinterface

// ===== rtl/dltq_cell.sv =====
// ----------------------------------------------------------------------------
// dltq_cell
// One slot of the timer chain: a tag and its delta after the slot before.
// ----------------------------------------------------------------------------
module dltq_cell #(
  parameter int TIME_WIDTH = dltq_pkg::TIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  dltq_pkg::cell_ctrl_t   ctrl,
  input  logic [31:0]            push_tag,
  input  logic [TIME_WIDTH-1:0]  push_delta,
  input  logic [31:0]            right_tag,
  input  logic [TIME_WIDTH-1:0]  right_delta,
  input  logic [TIME_WIDTH-1:0]  head_delta,
  output logic [31:0]            tag,
  output logic [TIME_WIDTH-1:0]  delta
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      tag   <= push_tag;
      delta <= push_delta;
    end else if (ctrl.pop) begin
      tag   <= right_tag;
      delta <= right_delta;
    end else if (ctrl.hwr) begin
      delta <= head_delta;
    end
  end

endmodule

// ===== rtl/delta_list_timer_queue.sv =====
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Retransmission timers kept as a delta list in a chain of cells.
// ----------------------------------------------------------------------------
// channel  dir  payload
// request  in   action, tag, timeout_ticks, elapsed_ticks
// result   out  kind, tag_res, status, last
//
// Each step pops the head cell and/or pushes at the tail, so a walk rotates
// the list once through the head. A full add skips the walk, and a tick on
// an empty list returns straight to idle.
// A stalled result holds a tick's expiries and the pending response; a new
// request is taken only when idle.
// Reset clears count, state and result valid only; cell contents need
// no clearing.
// ----------------------------------------------------------------------------
module delta_list_timer_queue #(
  parameter int CAPACITY   = dltq_pkg::CAPACITY_DEF,
  parameter int TIME_WIDTH = dltq_pkg::TIME_WIDTH_DEF
) (
  input logic     clk,
  input logic     rst,
  dltq_req_if.sink   request,
  dltq_res_if.source result
);

  `include "delta_list_timer_queue_defines.svh"

  localparam int TW = TIME_WIDTH;
  localparam int DW = (TW > 16) ? TW : 16;
  localparam int XW = (TW > 32) ? TW : 32;
  localparam int NW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ADD  = 5'b00010,
    ST_CAN  = 5'b00100,
    ST_TICK = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

  state_t        state, state_next;
  logic [NW-1:0] n, n_next;
  logic [NW-1:0] rem, rem_next;
  logic [TW-1:0] t, t_next;
  logic [TW-1:0] carry, carry_next;
  logic          carry_v, carry_v_next;
  logic          ins, ins_next;
  logic          found, found_next;
  logic [DW-1:0] debt, debt_next;
  logic [31:0]   tag_r, tag_r_next;
  logic [1:0]    kind_r, kind_r_next;
  logic [1:0]    stat_r, stat_r_next;

  logic          ov;
  logic [1:0]    o_kind;
  logic [31:0]   o_tag;
  logic [1:0]    o_status;
  logic          o_last;

  logic          out_load;
  logic [1:0]    ld_kind;
  logic [31:0]   ld_tag;
  logic [1:0]    ld_status;
  logic          ld_last;
  logic          can_emit;
  logic          req_acc;

  logic          pop, push, hwr;
  logic [31:0]   push_tag;
  logic [TW-1:0] push_delta;
  logic [TW-1:0] head_wr;

  logic [31:0]   c_tag   [CAPACITY];
  logic [TW-1:0] c_delta [CAPACITY];

  logic [XW-1:0] tmo_x;
  logic [TW-1:0] tmo_sat;
  logic [TW:0]   sum;
  logic [TW-1:0] sum_sat;
  logic [DW-1:0] d0_x, d1_x, debt_left;
  logic          exp_last;

  assign request.ready = (state == ST_IDLE) && !rst;
  assign req_acc       = request.valid && request.ready;
  assign can_emit      = !ov || result.ready;

  assign tmo_x   = XW'(request.timeout_ticks);
  assign tmo_sat = (tmo_x > XW'({TW{1'b1}})) ? {TW{1'b1}} : TW'(tmo_x);

  assign sum     = {1'b0, c_delta[0]} + {1'b0, carry};
  assign sum_sat = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

  assign d0_x      = DW'(c_delta[0]);
  assign d1_x      = DW'(c_delta[1]);
  assign debt_left = debt - d0_x;
  assign exp_last  = (n == NW'(1)) || (d1_x > debt_left);

  always_comb begin
    state_next   = state;
    n_next       = n;
    rem_next     = rem;
    t_next       = t;
    carry_next   = carry;
    carry_v_next = carry_v;
    ins_next     = ins;
    found_next   = found;
    debt_next    = debt;
    tag_r_next   = tag_r;
    kind_r_next  = kind_r;
    stat_r_next  = stat_r;
    pop          = 1'b0;
    push         = 1'b0;
    hwr          = 1'b0;
    push_tag     = c_tag[0];
    push_delta   = c_delta[0];
    head_wr      = c_delta[0];
    out_load     = 1'b0;
    ld_kind      = kind_r;
    ld_tag       = tag_r;
    ld_status    = stat_r;
    ld_last      = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (req_acc) begin
          tag_r_next = request.tag;
          rem_next   = n;
          if (request.action == dltq_pkg::ACT_ADD) begin
            kind_r_next = dltq_pkg::KIND_ADD;
            t_next      = tmo_sat;
            ins_next    = 1'b0;
            if (n == NW'(CAPACITY)) begin
              stat_r_next = dltq_pkg::STAT_FULL;
              state_next  = ST_RESP;
            end else begin
              stat_r_next = dltq_pkg::STAT_OK;
              state_next  = ST_ADD;
            end
          end else if (request.action == dltq_pkg::ACT_CANCEL) begin
            kind_r_next  = dltq_pkg::KIND_CANCEL;
            found_next   = 1'b0;
            carry_v_next = 1'b0;
            state_next   = ST_CAN;
          end else if (request.action == dltq_pkg::ACT_TICK) begin
            debt_next = DW'(request.elapsed_ticks);
            if (n != '0) state_next = ST_TICK;
          end
        end
      end
      ST_ADD: begin
        if (rem == '0) begin
          if (!ins) begin
            push       = 1'b1;
            push_tag   = tag_r;
            push_delta = t;
            n_next     = n + NW'(1);
          end
          state_next = ST_RESP;
        end else if (!ins && (t > c_delta[0])) begin
          pop      = 1'b1;
          push     = 1'b1;
          t_next   = t - c_delta[0];
          rem_next = rem - NW'(1);
        end else if (!ins) begin
          push       = 1'b1;
          push_tag   = tag_r;
          push_delta = t;
          hwr        = 1'b1;
          head_wr    = c_delta[0] - t;
          ins_next   = 1'b1;
          n_next     = n + NW'(1);
        end else begin
          pop      = 1'b1;
          push     = 1'b1;
          rem_next = rem - NW'(1);
        end
      end
      ST_CAN: begin
        if (rem == '0) begin
          stat_r_next = found ? dltq_pkg::STAT_OK : dltq_pkg::STAT_NOT_FOUND;
          state_next  = ST_RESP;
        end else if (!found && (c_tag[0] == tag_r)) begin
          pop          = 1'b1;
          n_next       = n - NW'(1);
          rem_next     = rem - NW'(1);
          found_next   = 1'b1;
          carry_next   = c_delta[0];
          carry_v_next = 1'b1;
        end else begin
          pop          = 1'b1;
          push         = 1'b1;
          push_delta   = carry_v ? sum_sat : c_delta[0];
          carry_v_next = 1'b0;
          rem_next     = rem - NW'(1);
        end
      end
      ST_TICK: begin
        if (d0_x > debt) begin
          hwr        = 1'b1;
          head_wr    = TW'(d0_x - debt);
          state_next = ST_IDLE;
        end else if (can_emit) begin
          pop       = 1'b1;
          n_next    = n - NW'(1);
          debt_next = debt_left;
          out_load  = 1'b1;
          ld_kind   = dltq_pkg::KIND_EXPIRE;
          ld_tag    = c_tag[0];
          ld_status = dltq_pkg::STAT_OK;
          ld_last   = exp_last;
          // new head still owes the leftover debt
          if (n == NW'(1)) state_next = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (can_emit) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n     <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      n     <= n_next;
      if (out_load) ov <= 1'b1;
      else if (result.ready) ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rem     <= rem_next;
    t       <= t_next;
    carry   <= carry_next;
    carry_v <= carry_v_next;
    ins     <= ins_next;
    found   <= found_next;
    debt    <= debt_next;
    tag_r   <= tag_r_next;
    kind_r  <= kind_r_next;
    stat_r  <= stat_r_next;
    if (out_load) begin
      o_kind   <= ld_kind;
      o_tag    <= ld_tag;
      o_status <= ld_status;
      o_last   <= ld_last;
    end
  end

  assign result.valid   = ov;
  assign result.kind    = o_kind;
  assign result.tag_res = o_tag;
  assign result.status  = o_status;
  assign result.last    = o_last;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    dltq_pkg::cell_ctrl_t ctrl;
    logic [31:0]          r_tag;
    logic [TW-1:0]        r_delta;

    if (i < CAPACITY - 1) begin : g_mid
      assign r_tag   = c_tag[i+1];
      assign r_delta = c_delta[i+1];
    end else begin : g_end
      assign r_tag   = c_tag[i];
      assign r_delta = c_delta[i];
    end

    assign ctrl.pop  = pop;
    assign ctrl.load = push && (NW'(i) == (pop ? n - NW'(1) : n));
    assign ctrl.hwr  = (i == 0) && hwr;

    dltq_cell #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .push_tag   (push_tag),
      .push_delta (push_delta),
      .right_tag  (r_tag),
      .right_delta(r_delta),
      .head_delta (head_wr),
      .tag        (c_tag[i]),
      .delta      (c_delta[i])
    );
  end

  `DLTQ_ASSERT_NOW(a_count_bound, 1'b1, n <= NW'(CAPACITY), "entry count above capacity")
  `DLTQ_ASSERT_NOW(a_walk_rem, (state == ST_ADD) || (state == ST_CAN), rem <= n,
                   "walk counter above entry count")
  `DLTQ_ASSERT_NXT(a_full_add,
                   req_acc && (request.action == dltq_pkg::ACT_ADD) && (n == NW'(CAPACITY)),
                   (n == NW'(CAPACITY)) && (state == ST_RESP), "full add changed the list")
  `DLTQ_ASSERT_NOW(a_expire_more, out_load && (state == ST_TICK) && !ld_last, n >= NW'(2),
                   "non-final expiry with no entry behind it")

endmodule

// ===== verif/delta_list_timer_queue_tb.sv =====
// ----------------------------------------------------------------------------
// delta_list_timer_queue_tb
// Self-checking bench for the delta list timer queue. A directed sequence
// covers the empty list, equal deadlines, zero deltas, overrun across
// expiries, a full list and missing tags; random add, cancel and tick
// requests follow under bursty input and a stalling result side. A built-in
// model of the delta list predicts every result, and each one is checked.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY   = dltq_pkg::CAPACITY_DEF;
  localparam int TIME_WIDTH = dltq_pkg::TIME_WIDTH_DEF;
  localparam longint unsigned TIME_MAX = (64'd1 << TIME_WIDTH) - 64'd1;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int RANDOM_REQUESTS = 140;
  localparam int TAG_POOL        = 16;
  localparam int MAX_SHOWN       = 10;
  localparam int HOLD_AFTER      = 70;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 60;
  localparam int QUIET_LIMIT     = 2000;

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] tag;
    logic [31:0] timeout_ticks;
    logic [15:0] elapsed_ticks;
  } timer_request_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tag;
    logic [1:0]  status;
    logic        last;
  } timer_result_t;

  class timer_queue_checker;
    longint unsigned list_delta[$];
    logic [31:0]     list_tag[$];
    timer_result_t   pending_results[$];
    int failures, results_seen;
    int n_add, n_cancel, n_tick, n_expired, n_full, n_missing;

    function void flag(string msg);
      failures++;
      if (failures <= MAX_SHOWN) $display("[%0t] ERROR: %s", $time, msg);
    endfunction

    function void expect_result(logic [1:0] kind, logic [31:0] tag, logic [1:0] status,
                                logic last);
      timer_result_t r;
      r.kind   = kind;
      r.tag    = tag;
      r.status = status;
      r.last   = last;
      pending_results.push_back(r);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function logic [31:0] pick_live_tag();
      if (list_tag.size() == 0) return $urandom;
      return list_tag[$urandom_range(0, list_tag.size() - 1)];
    endfunction

    // new timer goes after every strictly earlier deadline
    function logic [1:0] insert_timer(logic [31:0] tag, logic [31:0] timeout);
      longint unsigned rest;
      int pos;
      rest = (64'(timeout) > TIME_MAX) ? TIME_MAX : 64'(timeout);
      pos = 0;
      if (list_tag.size() >= CAPACITY) return dltq_pkg::STAT_FULL;
      while (pos < list_tag.size() && rest > list_delta[pos]) begin
        rest -= list_delta[pos];
        pos++;
      end
      if (pos < list_tag.size()) list_delta[pos] -= rest;
      list_delta.insert(pos, rest);
      list_tag.insert(pos, tag);
      return dltq_pkg::STAT_OK;
    endfunction

    function logic [1:0] cancel_timer(logic [31:0] tag);
      longint unsigned sum;
      int pos;
      pos = 0;
      while (pos < list_tag.size() && list_tag[pos] != tag) pos++;
      if (pos >= list_tag.size()) return dltq_pkg::STAT_NOT_FOUND;
      if (pos + 1 < list_tag.size()) begin
        sum = list_delta[pos + 1] + list_delta[pos];
        list_delta[pos + 1] = (sum > TIME_MAX) ? TIME_MAX : sum;
      end
      list_delta.delete(pos);
      list_tag.delete(pos);
      return dltq_pkg::STAT_OK;
    endfunction

    function void advance_time(logic [15:0] elapsed);
      longint unsigned debt;
      int fired;
      bit stop;
      debt  = 64'(elapsed);
      fired = 0;
      stop  = 0;
      while (!stop && list_tag.size() > 0 && fired < CAPACITY) begin
        if (list_delta[0] > debt) begin
          list_delta[0] -= debt;
          stop = 1;
        end else begin
          debt -= list_delta[0];
          expect_result(dltq_pkg::KIND_EXPIRE, list_tag[0], dltq_pkg::STAT_OK, 1'b0);
          void'(list_delta.pop_front());
          void'(list_tag.pop_front());
          fired++;
        end
      end
      if (fired > 0) pending_results[pending_results.size() - 1].last = 1'b1;
      n_expired += fired;
    endfunction

    function void note_request(timer_request_t r);
      logic [1:0] st;
      case (r.action)
        dltq_pkg::ACT_ADD: begin
          n_add++;
          st = insert_timer(r.tag, r.timeout_ticks);
          if (st == dltq_pkg::STAT_FULL) n_full++;
          expect_result(dltq_pkg::KIND_ADD, r.tag, st, 1'b1);
        end
        dltq_pkg::ACT_CANCEL: begin
          n_cancel++;
          st = cancel_timer(r.tag);
          if (st == dltq_pkg::STAT_NOT_FOUND) n_missing++;
          expect_result(dltq_pkg::KIND_CANCEL, r.tag, st, 1'b1);
        end
        dltq_pkg::ACT_TICK: begin
          n_tick++;
          advance_time(r.elapsed_ticks);
        end
        default: ;
      endcase
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        flag($sformatf("unexpected result: kind %0d tag %h status %0d last %0b",
                       got.kind, got.tag, got.status, got.last));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.tag !== want.tag ||
          got.status !== want.status || got.last !== want.last)
        flag($sformatf({"result %0d: expected kind %0d tag %h status %0d last %0b, ",
                        "got kind %0d tag %h status %0d last %0b"}, results_seen,
                       want.kind, want.tag, want.status, want.last,
                       got.kind, got.tag, got.status, got.last));
    endfunction
  endclass

  logic clk;
  logic rst;

  dltq_req_if request_bus();
  dltq_res_if result_bus();

  timer_queue_checker sb = new();

  logic [31:0] tag_pool[TAG_POOL];

  delta_list_timer_queue #(
    .CAPACITY  (CAPACITY),
    .TIME_WIDTH(TIME_WIDTH)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .request(request_bus),
    .result (result_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic timer_request_t mk_request(logic [1:0] action, logic [31:0] tag,
                                                logic [31:0] timeout, logic [15:0] elapsed);
    timer_request_t r;
    r.action        = action;
    r.tag           = tag;
    r.timeout_ticks = timeout;
    r.elapsed_ticks = elapsed;
    return r;
  endfunction

  task automatic send_request(timer_request_t r);
    request_bus.valid         <= 1'b1;
    request_bus.action        <= r.action;
    request_bus.tag           <= r.tag;
    request_bus.timeout_ticks <= r.timeout_ticks;
    request_bus.elapsed_ticks <= r.elapsed_ticks;
    @(posedge clk);
    while (!request_bus.ready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic wait_drained();
    request_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic timer_request_t random_request();
    timer_request_t r;
    int pick;
    r.action        = ACT_UNUSED;
    r.tag           = $urandom;
    r.timeout_ticks = $urandom;
    r.elapsed_ticks = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r.action = dltq_pkg::ACT_ADD;
      if ($urandom_range(0, 4) != 0) r.tag = tag_pool[$urandom_range(0, TAG_POOL - 1)];
      pick = $urandom_range(0, 19);
      if (pick < 17) r.timeout_ticks = $urandom_range(0, 3000);
      else if (pick == 17) r.timeout_ticks = 32'd0;
    end else if (pick < 62) begin
      r.action = dltq_pkg::ACT_CANCEL;
      pick = $urandom_range(0, 9);
      if (pick < 7) r.tag = sb.pick_live_tag();
      else if (pick < 9) r.tag = tag_pool[$urandom_range(0, TAG_POOL - 1)];
    end else if (pick < 97) begin
      r.action = dltq_pkg::ACT_TICK;
      pick = $urandom_range(0, 99);
      if (pick < 15) r.elapsed_ticks = 16'd0;
      else if (pick < 95) r.elapsed_ticks = 16'($urandom_range(1, 600));
    end
    return r;
  endfunction

  // stimulus
  initial begin
    int burst_left;
    int gap;
    rst                       <= 1'b1;
    request_bus.valid         <= 1'b0;
    request_bus.action        <= dltq_pkg::ACT_ADD;
    request_bus.tag           <= '0;
    request_bus.timeout_ticks <= '0;
    request_bus.elapsed_ticks <= '0;
    tag_pool[0] = 32'h0;
    tag_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < TAG_POOL; i++) tag_pool[i] = $urandom;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_request(mk_request(dltq_pkg::ACT_TICK, $urandom, $urandom, 16'hFFFF));
    send_request(mk_request(dltq_pkg::ACT_CANCEL, 32'h0, $urandom, 16'($urandom)));
    send_request(mk_request(dltq_pkg::ACT_ADD, 32'h0, 32'h0, 16'($urandom)));
    send_request(mk_request(dltq_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'($urandom)));
    send_request(mk_request(dltq_pkg::ACT_ADD, 32'h0000_00A1, 32'd100, 16'($urandom)));
    // equal deadline lands in front, leaving a zero delta behind it
    send_request(mk_request(dltq_pkg::ACT_ADD, 32'h0000_00B2, 32'd100, 16'($urandom)));
    send_request(mk_request(dltq_pkg::ACT_TICK, $urandom, $urandom, 16'd0));
    send_request(mk_request(dltq_pkg::ACT_TICK, $urandom, $urandom, 16'd50));
    send_request(mk_request(dltq_pkg::ACT_TICK, $urandom, $urandom, 16'hFFFF));
    send_request(mk_request(ACT_UNUSED, $urandom, $urandom, 16'($urandom)));
    for (int i = 0; i < CAPACITY - 1; i++)
      send_request(mk_request(dltq_pkg::ACT_ADD, 32'h100 + i, $urandom_range(0, 400),
                              16'($urandom)));
    send_request(mk_request(dltq_pkg::ACT_ADD, 32'h5A5A_5A5A, 32'd1, 16'($urandom)));
    send_request(mk_request(dltq_pkg::ACT_CANCEL, 32'hFFFF_FFFF, $urandom, 16'($urandom)));
    send_request(mk_request(dltq_pkg::ACT_CANCEL, 32'h107, $urandom, 16'($urandom)));
    send_request(mk_request(dltq_pkg::ACT_TICK, $urandom, $urandom, 16'hFFFF));
    wait_drained();

    burst_left = 0;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS / 2) wait_drained();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          request_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      send_request(random_request());
      burst_left--;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d adds (%0d on a full list), %0d cancels (%0d missing tag), %0d ticks",
             sb.n_add, sb.n_full, sb.n_cancel, sb.n_missing, sb.n_tick);
    $display("Checked %0d results including %0d expiries, %0d mismatches",
             sb.results_seen, sb.n_expired, sb.failures);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // result side: changing stall patterns, one long hold-off
  initial begin
    rx_mode_e mode;
    int mode_left;
    bit held;
    mode      = RX_OPEN;
    mode_left = 0;
    held      = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sb.results_seen >= HOLD_AFTER) begin
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   result_bus.ready <= 1'b1;
          RX_CHOPPY: result_bus.ready <= ($urandom_range(0, 1) == 1);
          default:   result_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready)
      sb.check_result({result_bus.kind, result_bus.tag_res, result_bus.status,
                       result_bus.last});
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (request_bus.valid && request_bus.ready) ||
          (result_bus.valid && result_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no request or result for %0d cycles", QUIET_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule
